// ----- hw/rtl/mrc_pkg.sv -----
// ----------------------------------------------------------------------------
// mrc_pkg: shared types and constants for the Modbus RTU response checker
// Frame phase codes, result kinds and CRC-16 constants.
// ----------------------------------------------------------------------------
package mrc_pkg;

  // CRC-16 (reflected form) constants
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Position within a frame
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_FUNC   = 3'd1,
    PH_COUNT  = 3'd2,
    PH_DATA   = 3'd3,
    PH_CRC_LO = 3'd4,
    PH_CRC_HI = 3'd5
  } phase_t;

  // Kind of result item
  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_CRC_OK  = 2'd1,
    KIND_CRC_BAD = 2'd2
  } kind_t;

endpackage

// ----- hw/rtl/mrc_if.sv -----
// ----------------------------------------------------------------------------
// mrc_if: valid/ready channels of the Modbus RTU response checker
// mrc_in_if carries received bytes; mrc_out_if carries result items.
// ----------------------------------------------------------------------------
interface mrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface mrc_out_if;
  logic              valid;
  logic              ready;
  mrc_pkg::kind_t    kind;
  logic [7:0]        payload_byte;
  logic [7:0]        byte_position;
  logic [7:0]        function_code;
  logic [7:0]        byte_count;

  modport source (output valid, output kind, output payload_byte, output byte_position,
                  output function_code, output byte_count, input ready);
  modport sink   (input valid, input kind, input payload_byte, input byte_position,
                  input function_code, input byte_count, output ready);
endinterface

// ----- hw/rtl/mrc_crc_byte.sv -----
// ----------------------------------------------------------------------------
// mrc_crc_byte: one-byte update of the reflected CRC-16
// Folds one byte into the running CRC, eight bit steps, LSB first.
// ----------------------------------------------------------------------------
module mrc_crc_byte (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [15:0] crc_out
);
  import mrc_pkg::*;

  // Shift out eight bits, folding in the polynomial on a set LSB
  always_comb begin
    logic [15:0] acc;
    acc = crc_in ^ {8'h00, data_in};
    for (int k = 0; k < 8; k++) begin
      if (acc[0]) begin
        acc = (acc >> 1) ^ CRC_POLY;
      end else begin
        acc = acc >> 1;
      end
    end
    crc_out = acc;
  end

endmodule

// ----- hw/rtl/modbus_rtu_response_checker.sv -----
// ----------------------------------------------------------------------------
// modbus_rtu_response_checker: Modbus RTU read-response frame checker
// Filters frames by address, forwards data bytes and checks the CRC-16.
// ----------------------------------------------------------------------------
//  channel   dir  handshake         payload
//  in_ch     in   valid/ready       rx_byte[7:0], frame_start
//  out_ch    out  valid/ready       kind, payload_byte, byte_position,
//                                   function_code, byte_count
//  cfg       in   cfg_we (no wait)  cfg_wdata[7:0] = device_address
//
//  One item per cycle while in_ch.ready is high: a byte is consumed in the
//  cycle it is accepted, and the CRC byte update plus phase step settle before
//  the result register. Result valid rises in the cycle after an accept that makes a result.
//  in_ch.ready stays high while the result register is empty or being drained,
//  so a stall on out_ch holds the input only when a result is waiting.
//  Synchronous active-low reset: phase idle, CRC 0xFFFF, address 1.
// ----------------------------------------------------------------------------
module modbus_rtu_response_checker (
  input  logic             clk,
  input  logic             rst_n,
  mrc_in_if.sink           in_ch,
  mrc_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_wdata
);
  import mrc_pkg::*;

  logic [7:0]  dev_addr_r;
  phase_t      phase_r, phase_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [7:0]  index_r, index_nxt;
  logic [7:0]  func_r, func_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;

  logic        out_valid_r;
  kind_t       out_kind_r;
  logic [7:0]  out_payload_r, out_pos_r, out_func_r, out_count_r;

  logic        accept;
  logic        res_valid;
  kind_t       res_kind;
  logic [7:0]  res_payload, res_pos;
  logic [15:0] crc_base, crc_upd;
  logic [7:0]  index_inc;
  logic [7:0]  b;

  assign b          = in_ch.rx_byte;
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept     = in_ch.valid && in_ch.ready;
  assign index_inc  = index_r + 8'd1;

  // Restart the CRC on a frame start byte
  assign crc_base = in_ch.frame_start ? CRC_INIT : crc_r;

  mrc_crc_byte u_crc (
    .crc_in  (crc_base),
    .data_in (b),
    .crc_out (crc_upd)
  );

  // Frame sequencing and result selection
  always_comb begin
    phase_nxt   = phase_r;
    crc_nxt     = crc_r;
    count_nxt   = count_r;
    index_nxt   = index_r;
    func_nxt    = func_r;
    crc_lo_nxt  = crc_lo_r;
    res_valid   = 1'b0;
    res_kind    = KIND_DATA;
    res_payload = 8'h00;
    res_pos     = 8'h00;
    if (in_ch.frame_start) begin
      if (b == dev_addr_r) begin
        crc_nxt   = crc_upd;
        phase_nxt = PH_FUNC;
      end else begin
        phase_nxt = PH_IDLE;
      end
    end else begin
      case (phase_r)
        PH_FUNC: begin
          func_nxt  = b;
          crc_nxt   = crc_upd;
          phase_nxt = PH_COUNT;
        end
        PH_COUNT: begin
          count_nxt = b;
          crc_nxt   = crc_upd;
          index_nxt = 8'h00;
          phase_nxt = (b == 8'h00) ? PH_CRC_LO : PH_DATA;
        end
        PH_DATA: begin
          res_valid   = 1'b1;
          res_kind    = KIND_DATA;
          res_payload = b;
          res_pos     = index_r;
          crc_nxt     = crc_upd;
          index_nxt   = index_inc;
          if (index_inc == count_r) begin
            phase_nxt = PH_CRC_LO;
          end
        end
        PH_CRC_LO: begin
          crc_lo_nxt = b;
          phase_nxt  = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          res_valid = 1'b1;
          res_kind  = ({b, crc_lo_r} == crc_r) ? KIND_CRC_OK : KIND_CRC_BAD;
          phase_nxt = PH_IDLE;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  // Advance frame state on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      crc_r    <= CRC_INIT;
      count_r  <= 8'h00;
      index_r  <= 8'h00;
      func_r   <= 8'h00;
      crc_lo_r <= 8'h00;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      crc_r    <= crc_nxt;
      count_r  <= count_nxt;
      index_r  <= index_nxt;
      func_r   <= func_nxt;
      crc_lo_r <= crc_lo_nxt;
    end
  end

  // Hold the device address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= 8'd1;
    end else if (cfg_we) begin
      dev_addr_r <= cfg_wdata;
    end
  end

  // Load the result register, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      out_kind_r    <= res_kind;
      out_payload_r <= res_payload;
      out_pos_r     <= res_pos;
      out_func_r    <= func_r;
      out_count_r   <= count_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.kind          = out_kind_r;
  assign out_ch.payload_byte  = out_payload_r;
  assign out_ch.byte_position = out_pos_r;
  assign out_ch.function_code = out_func_r;
  assign out_ch.byte_count    = out_count_r;

endmodule
